### sv/cse_pkg.sv
package cse_pkg;

   // datapath format
   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_TERMS  = 16;
   localparam int COEF_IDX_W = $clog2(MAX_TERMS);
   localparam int TERM_CNT_W = 5;

   // mapping divider widths
   localparam int NUM_W     = DATA_W + 3;
   localparam int DEN_W     = DATA_W + 1;
   localparam int DIV_STEPS = DATA_W / 2;

   // recurrence accumulator width
   localparam int ACC_W = 2 * DATA_W + 2;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOMAIN_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOMAIN_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_COUNT  = 2'd2;

   // request actions
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   // reset values of the configuration registers
   localparam logic signed [DATA_W-1:0]   DOMAIN_LOW_RST  = 32'shFFFF_0000;
   localparam logic signed [DATA_W-1:0]   DOMAIN_HIGH_RST = 32'sh0001_0000;
   localparam logic [TERM_CNT_W-1:0]      TERM_COUNT_RST  = 5'd1;

   // saturation bounds
   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // mapped point handed from the divider to the sequencer
   typedef struct packed {
      logic              done;
      logic              sat;
      logic [DATA_W-1:0] y;
   } cse_map_type;

endpackage

### sv/chebyshev_series_evaluator.sv
// Chebyshev series evaluator, Clenshaw recurrence in Q15.16 fixed point.
// Request channel (req_): a load request writes req_coef_value into slot
// req_coef_index of the coefficient table and is done in the cycle it is
// accepted; an evaluate request maps req_point onto [-1,1] and sums the
// first term_count coefficients. Only evaluate requests give a response.
// Response channel (rsp_): value, saturation flag, domain error flag and a
// copy of req_batch_end. Configuration (csr_) is ready whenever reset is
// low; write it only while no evaluation is in flight.
// An evaluation runs the mapping divider at two quotient bits a cycle,
// reads the first coefficient, then for each of n = min(term_count, 16)
// terms (at least 1) reads, multiplies and accumulates around the single
// multiplier, and finally loads the output register. A zero-width domain
// skips the divider and the recurrence. An evaluation must finish before
// the next request is accepted; load requests are taken one a cycle while
// no evaluation is in flight.
// A finished response sits in the output register, so the next request is
// taken while it waits; if the receiver stalls with a response still held,
// the next evaluation waits at its end until the register frees. Reset
// restores the domain to [-1,1] and term_count to 1; the table is not cleared.
module chebyshev_series_evaluator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic [cse_pkg::COEF_IDX_W-1:0]       req_coef_index,
   input  logic signed [cse_pkg::DATA_W-1:0]    req_coef_value,
   input  logic signed [cse_pkg::DATA_W-1:0]    req_point,
   input  logic                                 req_batch_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cse_pkg::DATA_W-1:0]    rsp_series_value,
   output logic                                 rsp_saturated,
   output logic                                 rsp_domain_error,
   output logic                                 rsp_batch_end_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cse_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cse_pkg::DATA_W-1:0]           csr_data
);
   import cse_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAP, ST_READ, ST_MUL, ST_ACC, ST_DONE
   } state_type;

   state_type                  state_ff;
   logic signed [DATA_W-1:0]   domain_low_ff;
   logic signed [DATA_W-1:0]   domain_high_ff;
   logic [TERM_CNT_W-1:0]      term_count_ff;
   logic signed [DATA_W-1:0]   y_ff;
   logic signed [DATA_W-1:0]   b1_ff;
   logic signed [DATA_W-1:0]   b2_ff;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic signed [DATA_W-1:0]   coef_ff;
   logic [COEF_IDX_W-1:0]      k_ff;
   logic                       sat_ff;
   logic                       batch_ff;
   logic signed [DATA_W-1:0]   res_value_ff;
   logic                       res_sat_ff;
   logic                       res_err_ff;
   logic                       rsp_valid_ff;
   logic signed [DATA_W-1:0]   rsp_value_ff;
   logic                       rsp_sat_ff;
   logic                       rsp_err_ff;
   logic                       rsp_batch_ff;

   logic                       req_fire;
   logic                       load_fire;
   logic                       eval_fire;
   logic                       domain_err;
   logic                       map_start;
   cse_map_type                map_res;
   logic [COEF_IDX_W-1:0]      rd_addr;
   logic [DATA_W-1:0]          rd_data;
   logic [TERM_CNT_W-1:0]      term_m1;
   logic [COEF_IDX_W-1:0]      k_in;
   logic                       last_term;
   logic signed [2*DATA_W-1:0] prod_sh;
   logic signed [DATA_W-1:0]   coef_term;
   logic signed [ACC_W-1:0]    acc_in;
   logic                       clip_hi;
   logic                       clip_lo;
   logic signed [DATA_W-1:0]   b0_in;

   // handshakes
   assign req_ready = (state_ff == ST_IDLE) & ~reset;
   assign csr_ready = ~reset;
   assign req_fire  = req_valid & req_ready;
   assign load_fire = req_fire & (req_action == ACT_LOAD);
   assign eval_fire = req_fire & (req_action == ACT_EVAL);
   assign domain_err = (domain_low_ff == domain_high_ff);
   assign map_start  = eval_fire & ~domain_err;

   // coefficient table
   cse_coef_ram u_coef_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (req_coef_index),
      .wr_data (req_coef_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // point mapping onto [-1,1]
   cse_map_div u_map_div (
      .clock       (clock),
      .reset       (reset),
      .start       (map_start),
      .point       (req_point),
      .domain_low  (domain_low_ff),
      .domain_high (domain_high_ff),
      .map_out     (map_res)
   );

   // highest coefficient index used, clamped to the table
   always_comb begin
      term_m1 = term_count_ff - 1'b1;
      if (term_count_ff == '0) begin
         k_in = '0;
      end else if (term_count_ff > TERM_CNT_W'(MAX_TERMS)) begin
         k_in = COEF_IDX_W'(MAX_TERMS - 1);
      end else begin
         k_in = term_m1[COEF_IDX_W-1:0];
      end
   end

   // read ahead the next coefficient while accumulating
   assign rd_addr = (state_ff == ST_ACC) ? (k_ff - 1'b1) : k_ff;

   // recurrence step, or the closing step when on c0
   always_comb begin
      last_term = (k_ff == '0);
      prod_sh   = last_term ? (prod_ff >>> FRAC_BITS) : (prod_ff >>> (FRAC_BITS - 1));
      coef_term = last_term ? (coef_ff >>> 1) : coef_ff;
      acc_in    = $signed({{(ACC_W-2*DATA_W){prod_sh[2*DATA_W-1]}}, prod_sh})
                - $signed({{(ACC_W-DATA_W){b2_ff[DATA_W-1]}}, b2_ff})
                + $signed({{(ACC_W-DATA_W){coef_term[DATA_W-1]}}, coef_term});
      clip_hi   = ~acc_in[ACC_W-1] & (acc_in[ACC_W-1:DATA_W-1] != '0);
      clip_lo   = acc_in[ACC_W-1] & (acc_in[ACC_W-1:DATA_W-1] != '1);
      if (clip_hi) begin
         b0_in = SAT_MAX;
      end else if (clip_lo) begin
         b0_in = SAT_MIN;
      end else begin
         b0_in = acc_in[DATA_W-1:0];
      end
   end

   // sequencer, configuration and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         domain_low_ff  <= DOMAIN_LOW_RST;
         domain_high_ff <= DOMAIN_HIGH_RST;
         term_count_ff  <= TERM_COUNT_RST;
      end else begin
         // configuration writes
         if (csr_valid) begin
            case (csr_index)
               CSR_DOMAIN_LOW:  domain_low_ff  <= csr_data;
               CSR_DOMAIN_HIGH: domain_high_ff <= csr_data;
               CSR_TERM_COUNT:  term_count_ff  <= csr_data[TERM_CNT_W-1:0];
               default: ;
            endcase
         end

         // response taken with nothing ready to replace it
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (eval_fire) begin
                  batch_ff <= req_batch_end;
                  if (domain_err) begin
                     res_value_ff <= '0;
                     res_sat_ff   <= 1'b0;
                     res_err_ff   <= 1'b1;
                     state_ff     <= ST_DONE;
                  end else begin
                     state_ff <= ST_MAP;
                  end
               end
            end
            ST_MAP: begin
               if (map_res.done) begin
                  y_ff     <= map_res.y;
                  sat_ff   <= map_res.sat;
                  b1_ff    <= '0;
                  b2_ff    <= '0;
                  k_ff     <= k_in;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= y_ff * b1_ff;
               coef_ff  <= rd_data;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (last_term) begin
                  res_value_ff <= b0_in;
                  res_sat_ff   <= sat_ff | clip_hi | clip_lo;
                  res_err_ff   <= 1'b0;
                  state_ff     <= ST_DONE;
               end else begin
                  b2_ff    <= b1_ff;
                  b1_ff    <= b0_in;
                  sat_ff   <= sat_ff | clip_hi | clip_lo;
                  k_ff     <= k_ff - 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= res_value_ff;
                  rsp_sat_ff   <= res_sat_ff;
                  rsp_err_ff   <= res_err_ff;
                  rsp_batch_ff <= batch_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_series_value  = rsp_value_ff;
   assign rsp_saturated     = rsp_sat_ff;
   assign rsp_domain_error  = rsp_err_ff;
   assign rsp_batch_end_out = rsp_batch_ff;

endmodule

### sv/cse_coef_ram.sv
module cse_coef_ram (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [cse_pkg::COEF_IDX_W-1:0]   wr_addr,
   input  logic [cse_pkg::DATA_W-1:0]       wr_data,
   input  logic [cse_pkg::COEF_IDX_W-1:0]   rd_addr,
   output logic [cse_pkg::DATA_W-1:0]       rd_data
);
   import cse_pkg::*;

   logic [DATA_W-1:0] mem [MAX_TERMS];
   logic [DATA_W-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/cse_map_div.sv
module cse_map_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [cse_pkg::DATA_W-1:0]  point,
   input  logic signed [cse_pkg::DATA_W-1:0]  domain_low,
   input  logic signed [cse_pkg::DATA_W-1:0]  domain_high,
   output cse_pkg::cse_map_type               map_out
);
   import cse_pkg::*;

   localparam int INT_BITS = DATA_W - FRAC_BITS;
   localparam int CMP_W    = DATA_W + INT_BITS;
   localparam int STEP_W   = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {DIV_IDLE, DIV_PREP, DIV_RUN, DIV_FIN} div_state_type;

   div_state_type            state_ff;
   logic signed [NUM_W-1:0]  num_ff;
   logic signed [DEN_W-1:0]  den_ff;
   logic                     neg_ff;
   logic                     ovf_ff;
   logic [DATA_W-1:0]        divisor_ff;
   logic [DATA_W-1:0]        rem_ff;
   logic [DATA_W-1:0]        low_ff;
   logic [DATA_W-1:0]        quot_ff;
   logic [STEP_W-1:0]        step_ff;

   logic signed [NUM_W-1:0]  num_in;
   logic signed [DEN_W-1:0]  den_in;
   logic signed [NUM_W-1:0]  num_neg;
   logic signed [DEN_W-1:0]  den_neg;
   logic [NUM_W-2:0]         num_abs;
   logic [DATA_W-1:0]        den_abs;
   logic                     ovf_in;
   logic [DATA_W:0]          trial1;
   logic [DATA_W:0]          part1;
   logic [DATA_W:0]          trial2;
   logic [DATA_W:0]          part2;
   logic                     ge1;
   logic                     ge2;
   logic [DATA_W-1:0]        quot_neg;
   logic [DATA_W-1:0]        y_out;
   logic                     sat_out;

   // numerator 2x - lo - hi and denominator hi - lo
   always_comb begin
      num_in = $signed({{(NUM_W-DATA_W-1){point[DATA_W-1]}}, point, 1'b0})
             - $signed({{(NUM_W-DATA_W){domain_low[DATA_W-1]}}, domain_low})
             - $signed({{(NUM_W-DATA_W){domain_high[DATA_W-1]}}, domain_high});
      den_in = $signed({domain_high[DATA_W-1], domain_high})
             - $signed({domain_low[DATA_W-1], domain_low});
   end

   // magnitudes and early overflow test on the quotient
   always_comb begin
      num_neg = -num_ff;
      den_neg = -den_ff;
      num_abs = num_ff[NUM_W-1] ? num_neg[NUM_W-2:0] : num_ff[NUM_W-2:0];
      den_abs = den_ff[DEN_W-1] ? den_neg[DATA_W-1:0] : den_ff[DATA_W-1:0];
      ovf_in  = {{(CMP_W-NUM_W+1){1'b0}}, num_abs} >= {den_abs, {INT_BITS{1'b0}}};
   end

   // two restoring quotient bits per cycle
   always_comb begin
      trial1 = {rem_ff, low_ff[DATA_W-1]};
      ge1    = trial1 >= {1'b0, divisor_ff};
      part1  = ge1 ? (trial1 - {1'b0, divisor_ff}) : trial1;
      trial2 = {part1[DATA_W-1:0], low_ff[DATA_W-2]};
      ge2    = trial2 >= {1'b0, divisor_ff};
      part2  = ge2 ? (trial2 - {1'b0, divisor_ff}) : trial2;
   end

   // sign and clipping of the quotient
   always_comb begin
      quot_neg = '0 - quot_ff;
      y_out    = quot_ff;
      sat_out  = 1'b0;
      if (ovf_ff) begin
         y_out   = neg_ff ? SAT_MIN : SAT_MAX;
         sat_out = 1'b1;
      end else if (neg_ff) begin
         if (quot_ff > SAT_MIN) begin
            y_out   = SAT_MIN;
            sat_out = 1'b1;
         end else begin
            y_out = quot_neg;
         end
      end else if (quot_ff[DATA_W-1]) begin
         y_out   = SAT_MAX;
         sat_out = 1'b1;
      end
   end

   // divider sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         case (state_ff)
            DIV_IDLE: begin
               if (start) begin
                  num_ff   <= num_in;
                  den_ff   <= den_in;
                  state_ff <= DIV_PREP;
               end
            end
            DIV_PREP: begin
               neg_ff     <= num_ff[NUM_W-1] ^ den_ff[DEN_W-1];
               ovf_ff     <= ovf_in;
               divisor_ff <= den_abs;
               rem_ff     <= DATA_W'(num_abs >> INT_BITS);
               low_ff     <= {num_abs[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
               quot_ff    <= '0;
               step_ff    <= '0;
               state_ff   <= DIV_RUN;
            end
            DIV_RUN: begin
               rem_ff  <= part2[DATA_W-1:0];
               low_ff  <= {low_ff[DATA_W-3:0], 2'b00};
               quot_ff <= {quot_ff[DATA_W-3:0], ge1, ge2};
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  state_ff <= DIV_FIN;
               end
            end
            DIV_FIN: begin
               state_ff <= DIV_IDLE;
            end
            default: begin
               state_ff <= DIV_IDLE;
            end
         endcase
      end
   end

   assign map_out.done = (state_ff == DIV_FIN);
   assign map_out.sat  = sat_out;
   assign map_out.y    = y_out;

endmodule

### sim/chebyshev_series_evaluator_tb.sv
`timescale 1ns / 1ps

module chebyshev_series_evaluator_tb;
   import cse_pkg::*;

   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 400;
   localparam int RAND_PHASES  = 10;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     sat;
      logic                     derr;
      logic                     bend;
   } series_result_type;

   // clenshaw predictor plus queue of awaited responses
   class series_scoreboard_type;
      logic signed [DATA_W-1:0] coef_table [MAX_TERMS];
      logic signed [DATA_W-1:0] dom_low;
      logic signed [DATA_W-1:0] dom_high;
      logic [TERM_CNT_W-1:0]    terms;
      series_result_type        awaited_q [$];
      int errors;
      int loads;
      int evals;
      int checked;

      function new();
         dom_low  = DOMAIN_LOW_RST;
         dom_high = DOMAIN_HIGH_RST;
         terms    = TERM_COUNT_RST;
         foreach (coef_table[i]) coef_table[i] = '0;
         errors  = 0;
         loads   = 0;
         evals   = 0;
         checked = 0;
      endfunction

      function int pending();
         return awaited_q.size();
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
         case (idx)
            CSR_DOMAIN_LOW:  dom_low  = data;
            CSR_DOMAIN_HIGH: dom_high = data;
            CSR_TERM_COUNT:  terms    = data[TERM_CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [DATA_W-1:0] clip_word(longint v, inout bit flag);
         if (v > longint'(SAT_MAX)) begin
            flag = 1'b1;
            return SAT_MAX;
         end
         if (v < longint'(SAT_MIN)) begin
            flag = 1'b1;
            return SAT_MIN;
         end
         return v[DATA_W-1:0];
      endfunction

      // map x onto [-1,1]; division truncates toward zero
      function logic signed [DATA_W-1:0] map_to_unit(logic signed [DATA_W-1:0] x,
                                                     inout bit flag);
         longint num;
         longint den;
         longint quo;
         longint rem;
         longint one;
         longint lim;
         num = 2 * longint'(x) - longint'(dom_low) - longint'(dom_high);
         den = longint'(dom_high) - longint'(dom_low);
         quo = num / den;
         rem = num % den;
         one = longint'(1) << FRAC_BITS;
         lim = longint'(1) << (DATA_W - FRAC_BITS);
         if (quo > lim) begin
            flag = 1'b1;
            return SAT_MAX;
         end
         if (quo < -lim) begin
            flag = 1'b1;
            return SAT_MIN;
         end
         return clip_word(quo * one + (rem * one) / den, flag);
      endfunction

      function void note_request(logic act, logic [COEF_IDX_W-1:0] idx,
                                 logic signed [DATA_W-1:0] cval,
                                 logic signed [DATA_W-1:0] pnt, logic bend);
         series_result_type r;
         bit sat;
         logic signed [DATA_W-1:0] y;
         logic signed [DATA_W-1:0] b0;
         logic signed [DATA_W-1:0] b1;
         logic signed [DATA_W-1:0] b2;
         longint acc;
         int n;
         if (act == ACT_LOAD) begin
            coef_table[idx] = cval;
            loads++;
            return;
         end
         evals++;
         r.bend = bend;
         if (dom_low == dom_high) begin
            r.value = '0;
            r.sat   = 1'b0;
            r.derr  = 1'b1;
            awaited_q.push_back(r);
            return;
         end
         sat = 1'b0;
         b1  = '0;
         b2  = '0;
         y   = map_to_unit(pnt, sat);
         n   = (terms > MAX_TERMS) ? MAX_TERMS : int'(terms);
         // backward recurrence, shifts round toward minus infinity
         for (int k = n - 1; k >= 1; k--) begin
            acc = ((longint'(y) * longint'(b1)) >>> (FRAC_BITS - 1))
                  - longint'(b2) + longint'(coef_table[k]);
            b0 = clip_word(acc, sat);
            b2 = b1;
            b1 = b0;
         end
         acc = ((longint'(y) * longint'(b1)) >>> FRAC_BITS) - longint'(b2)
               + (longint'(coef_table[0]) >>> 1);
         r.value = clip_word(acc, sat);
         r.sat   = sat;
         r.derr  = 1'b0;
         awaited_q.push_back(r);
      endfunction

      function void check_response(logic signed [DATA_W-1:0] value, logic sat,
                                   logic derr, logic bend);
         series_result_type e;
         if (awaited_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, actual value %h sat %b err %b end %b",
                     $time, value, sat, derr, bend);
            return;
         end
         e = awaited_q.pop_front();
         checked++;
         if (value !== e.value || sat !== e.sat || derr !== e.derr || bend !== e.bend) begin
            errors++;
            $display("%0t: mismatch, expected %h/%b/%b/%b, actual %h/%b/%b/%b",
                     $time, e.value, e.sat, e.derr, e.bend, value, sat, derr, bend);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = ACT_LOAD;
   logic [COEF_IDX_W-1:0] req_coef_index = '0;
   logic signed [DATA_W-1:0] req_coef_value = '0;
   logic signed [DATA_W-1:0] req_point = '0;
   logic req_batch_end = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_series_value;
   logic rsp_saturated;
   logic rsp_domain_error;
   logic rsp_batch_end_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;

   series_scoreboard_type sb = new();
   bit idle_on  = 1'b1;
   bit rsp_hold = 1'b0;
   int csr_writes = 0;
   logic signed [DATA_W-1:0] cur_lo;
   logic signed [DATA_W-1:0] cur_hi;

   chebyshev_series_evaluator u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_coef_index    (req_coef_index),
      .req_coef_value    (req_coef_value),
      .req_point         (req_point),
      .req_batch_end     (req_batch_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_series_value  (rsp_series_value),
      .rsp_saturated     (rsp_saturated),
      .rsp_domain_error  (rsp_domain_error),
      .rsp_batch_end_out (rsp_batch_end_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watch all three handshakes at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_series_value, rsp_saturated, rsp_domain_error,
                              rsp_batch_end_out);
         if (req_valid && req_ready)
            sb.note_request(req_action, req_coef_index, req_coef_value, req_point,
                            req_batch_end);
         if (csr_valid && csr_ready) begin
            sb.set_register(csr_index, csr_data);
            csr_writes++;
         end
      end
   end

   // receiver: random stall bursts and one long hold-off
   initial begin
      int burst;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_req(input logic act, input logic [COEF_IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] cval,
                           input logic signed [DATA_W-1:0] pnt, input logic bend);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_coef_index <= idx;
      req_coef_value <= cval;
      req_point      <= pnt;
      req_batch_end  <= bend;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_eval(input logic signed [DATA_W-1:0] pnt, input logic bend);
      send_req(ACT_EVAL, COEF_IDX_W'($urandom), $urandom, pnt, bend);
   endtask

   // hold off until every response is in, then let the datapath settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic signed [DATA_W-1:0] lo,
                            input logic signed [DATA_W-1:0] hi, input int terms);
      logic [DATA_W-1:0] tc_word;
      tc_word = $urandom;
      tc_word[TERM_CNT_W-1:0] = terms[TERM_CNT_W-1:0];
      write_csr(CSR_DOMAIN_LOW, lo);
      write_csr(CSR_DOMAIN_HIGH, hi);
      write_csr(CSR_TERM_COUNT, tc_word);
      csr_valid <= 1'b0;
      cur_lo = lo;
      cur_hi = hi;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_coef();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 14) return $signed($urandom_range(0, 262144)) - 131072;
      if (sel == 14) return SAT_MAX;
      if (sel == 15) return SAT_MIN;
      return $urandom;
   endfunction

   // mostly points inside the domain, some near the ends, some anywhere
   function automatic logic signed [DATA_W-1:0] pick_point();
      longint span;
      int sel;
      span = longint'(cur_hi) - longint'(cur_lo);
      sel  = $urandom_range(0, 9);
      if (sel < 7 && span > 0)
         return DATA_W'(longint'(cur_lo) + (longint'($urandom) % (span + 1)));
      if (sel < 9)
         return ($urandom_range(0, 1) ? cur_hi : cur_lo) + $signed($urandom_range(0, 32)) - 16;
      return $urandom;
   endfunction

   task automatic send_random_item();
      if ($urandom_range(0, 3) == 0)
         send_req(ACT_LOAD, COEF_IDX_W'($urandom), pick_coef(), $urandom,
                  1'($urandom_range(0, 1)));
      else
         send_eval(pick_point(), $urandom_range(0, 7) == 0);
   endtask

   task automatic random_config();
      logic signed [DATA_W-1:0] lo;
      logic signed [DATA_W-1:0] hi;
      int terms;
      case ($urandom_range(0, 9))
         0: begin
            lo = SAT_MIN;
            hi = SAT_MAX;
         end
         1: begin
            lo = $urandom;
            hi = lo;
         end
         2: begin
            lo = SAT_MAX;
            hi = SAT_MIN;
         end
         3: begin
            lo = $urandom;
            hi = $urandom;
         end
         default: begin
            lo = $signed($urandom_range(0, 2097152)) - 1048576;
            hi = lo + $signed($urandom_range(1, 1048576));
         end
      endcase
      terms = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      configure(lo, hi, terms);
   endtask

   initial begin
      int n_items;
      cur_lo = DOMAIN_LOW_RST;
      cur_hi = DOMAIN_HIGH_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every table slot, extremes and odd negative c0 for rounding
      send_req(ACT_LOAD, 4'd0, -32'sd32769, 32'sd0, 1'b0);
      send_req(ACT_LOAD, 4'd1, SAT_MIN, SAT_MAX, 1'b1);
      send_req(ACT_LOAD, 4'd2, SAT_MAX, SAT_MIN, 1'b0);
      send_req(ACT_LOAD, 4'd3, 32'sd0, 32'sd0, 1'b0);
      send_req(ACT_LOAD, 4'd4, -32'sd1, -32'sd1, 1'b1);
      for (int i = 5; i < MAX_TERMS; i++)
         send_req(ACT_LOAD, COEF_IDX_W'(i), pick_coef(), $urandom, 1'($urandom_range(0, 1)));

      // reset domain and one term
      send_eval(32'sd0, 1'b0);
      send_eval(SAT_MAX, 1'b1);
      send_eval(SAT_MIN, 1'b0);
      send_eval(-32'sd65536, 1'b0);
      send_eval(32'sd32769, 1'b1);
      wait_idle();

      // full range domain, all terms, big coefficients clip
      configure(SAT_MIN, SAT_MAX, MAX_TERMS);
      send_eval(SAT_MIN, 1'b0);
      send_eval(SAT_MAX, 1'b1);
      wait_idle();

      // zero-width domain
      configure(32'sd12345, 32'sd12345, MAX_TERMS);
      send_eval(32'sd12345, 1'b1);
      wait_idle();

      // term count of zero, then above the table size
      configure(-32'sd65536, 32'sd65536, 0);
      send_eval(32'sd16384, 1'b0);
      wait_idle();
      configure(-32'sd65536, 32'sd65536, 31);
      send_eval(-32'sd16384, 1'b1);
      wait_idle();

      // random phases; quiet handshakes for the last two
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph >= RAND_PHASES - 2) idle_on = 1'b0;
         random_config();
         if (ph == 3) begin
            // receiver holds off while the sender keeps offering
            idle_on  = 1'b0;
            rsp_hold = 1'b1;
            for (int i = 0; i < 8; i++) send_eval(pick_point(), i == 7);
            idle_on  = 1'b1;
         end
         n_items = $urandom_range(90, 110);
         for (int i = 0; i < n_items; i++) begin
            if (ph == 5 && i == n_items / 2) wait_idle();
            send_random_item();
         end
         wait_idle();
      end

      $display("summary: %0d loads, %0d evaluations, %0d responses checked, %0d register writes",
               sb.loads, sb.evals, sb.checked, csr_writes);
      $display("summary: full, reversed and zero-width domains, term counts 0 to 31, %0d-cycle hold",
               HOLD_CYCLES);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
sv/cse_pkg.sv
sv/cse_coef_ram.sv
sv/cse_map_div.sv
sv/chebyshev_series_evaluator.sv
sim/chebyshev_series_evaluator_tb.sv
